// ----- sv/status_frame_deframer_unit_assert.svh -----
// Assertion macros shared by the deframer.
`ifndef STATUS_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define STATUS_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// Condition must never hold outside reset.
`define SFD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sfd_pkg.sv -----
package sfd_pkg;

    localparam int BYTE_W = 8;
    localparam int IDX_W  = 6;

    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h55;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h00;
    localparam logic [BYTE_W-1:0] TRL_FIRST  = 8'h00;
    localparam logic [BYTE_W-1:0] TRL_SECOND = 8'hAA;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HDR2,
        PH_DATA,
        PH_TRL1,
        PH_TRL2,
        PH_DRAIN
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [IDX_W-1:0]  payload_index;
        logic              last_byte;
    } frame_item_t;

    typedef struct packed {
        logic shift;
        logic fill;
    } chain_ctrl_t;

endpackage

// ----- sv/sfd_stream_if.sv -----
interface sfd_stream_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/sfd_cell.sv -----
module sfd_cell (
    input  logic                      clk,
    input  logic                      shift,
    input  logic [sfd_pkg::BYTE_W-1:0] din,
    output logic [sfd_pkg::BYTE_W-1:0] dout
);
    import sfd_pkg::*;

    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;

    // hold unless the chain advances
    always_comb
    begin
        data_next = shift ? din : data_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign dout = data_reg;
endmodule

// ----- sv/sfd_parser.sv -----
module sfd_parser #(
    parameter int PAYLOAD_BYTES = 40
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rx_valid,
    input  logic [sfd_pkg::BYTE_W-1:0] rx_byte,
    output logic                       rx_ready,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [sfd_pkg::IDX_W-1:0]  out_index,
    output logic                       out_last,
    output sfd_pkg::chain_ctrl_t       chain
);
    import sfd_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [IDX_W-1:0]  count_reg;
    logic [IDX_W-1:0]  count_next;
    logic              rx_acc;
    logic              store;
    logic              pop;
    logic              at_last;

    assign at_last = (count_reg == LAST_IDX);
    // rx is open in every phase but the drain
    assign rx_acc  = rx_valid && (phase_reg != PH_DRAIN);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HUNT:
            begin
                if (rx_acc && rx_byte == HDR_FIRST)
                    phase_next = PH_HDR2;
            end
            PH_HDR2:
            begin
                if (rx_acc)
                    phase_next = (rx_byte == HDR_SECOND) ? PH_DATA : PH_HUNT;
            end
            PH_DATA:
            begin
                if (rx_acc && at_last)
                    phase_next = PH_TRL1;
            end
            PH_TRL1:
            begin
                if (rx_acc)
                    phase_next = (rx_byte == TRL_FIRST) ? PH_TRL2 : PH_HUNT;
            end
            PH_TRL2:
            begin
                if (rx_acc)
                    phase_next = (rx_byte == TRL_SECOND) ? PH_DRAIN : PH_HUNT;
            end
            PH_DRAIN:
            begin
                if (out_ready && at_last)
                    phase_next = PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        rx_ready  = 1'b1;
        out_valid = 1'b0;
        store     = 1'b0;
        pop       = 1'b0;
        case (phase_reg)
            PH_DATA:
            begin
                store = rx_acc;
            end
            PH_DRAIN:
            begin
                rx_ready  = 1'b0;
                out_valid = 1'b1;
                pop       = out_ready;
            end
            default:
            begin
                rx_ready = 1'b1;
            end
        endcase
    end

    // one counter serves both fill and drain; wrap at the last byte
    always_comb
    begin
        count_next = count_reg;
        if (store || pop)
            count_next = at_last ? '0 : count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    assign out_index   = count_reg;
    assign out_last    = at_last;
    assign chain.shift = store || pop;
    assign chain.fill  = store;
endmodule

// ----- sv/status_frame_deframer_unit.sv -----
// Status frame deframer. Bytes from a serial receiver arrive one request at a
// time on rx. The block hunts for the header 0x55 0x00, then shifts the next
// PAYLOAD_BYTES bytes into a row of byte cells, then checks the trailer
// 0x00 0xAA. Any wrong header or trailer byte drops the frame and returns
// to hunting. After a good trailer the row shifts out toward cell 0 and the
// block offers one frame request per payload byte, in order, with its index
// and with last_byte set on the final one. Rate: while parsing, rx is ready
// in every cycle and takes one byte per cycle. The drain moves one payload
// byte per accepted frame request, because the whole row advances one cell
// per pop; rx is held off for the whole drain. Payload cells need no reset
// and there is no clearing pass after reset.
`include "status_frame_deframer_unit_assert.svh"

module status_frame_deframer_unit #(
    parameter int PAYLOAD_BYTES = 40
) (
    input  logic               clk,
    input  logic               rst_n,
    sfd_stream_if.sink         rx,
    sfd_stream_if.source       frame
);
    import sfd_pkg::*;

    logic [BYTE_W-1:0] cell_q [PAYLOAD_BYTES];
    logic [BYTE_W-1:0] tail_din;
    logic [IDX_W-1:0]  out_index;
    logic              out_last;
    logic              rx_ready;
    logic              out_valid;
    chain_ctrl_t       chain;
    rx_item_t          rx_item;
    frame_item_t       frame_item;

    assign rx_item = rx.payload;

    // Parser state machine plus the shared fill / drain counter.
    sfd_parser #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx.valid),
        .rx_byte   (rx_item.rx_byte),
        .rx_ready  (rx_ready),
        .out_ready (frame.ready),
        .out_valid (out_valid),
        .out_index (out_index),
        .out_last  (out_last),
        .chain     (chain)
    );

    // New payload bytes enter at the tail; during drain the tail loads zero.
    assign tail_din = chain.fill ? rx_item.rx_byte : '0;

    // Row of byte cells. Each cell takes its neighbor's byte on every shift,
    // so after a full payload cell 0 holds byte 0 and a pop advances the row.
    for (genvar i = 0; i < PAYLOAD_BYTES; i++)
    begin : g_cell
        if (i == PAYLOAD_BYTES - 1)
        begin : g_tail
            sfd_cell u_cell (
                .clk   (clk),
                .shift (chain.shift),
                .din   (tail_din),
                .dout  (cell_q[i])
            );
        end
        else
        begin : g_body
            sfd_cell u_cell (
                .clk   (clk),
                .shift (chain.shift),
                .din   (cell_q[i+1]),
                .dout  (cell_q[i])
            );
        end
    end

    assign frame_item.payload_byte  = cell_q[0];
    assign frame_item.payload_index = out_index;
    assign frame_item.last_byte     = out_last;

    assign rx.ready      = rx_ready;
    assign frame.valid   = out_valid;
    assign frame.payload = frame_item;

    // Input and output are never open at the same time.
    `SFD_ASSERT_NEVER(a_no_overlap, clk, rst_n, rx_ready && out_valid,
        "rx ready while a frame drains")
    // Index stays inside the payload while a result is offered.
    `SFD_ASSERT_NEVER(a_index_range, clk, rst_n,
        out_valid && (out_index > IDX_W'(PAYLOAD_BYTES - 1)),
        "payload index out of range")
    // The last byte ends the drain.
    `SFD_ASSERT_NEXT(a_last_ends, clk, rst_n, out_valid && frame.ready && out_last,
        !out_valid && rx_ready, "drain did not end after last byte")
    // Any other pop keeps the drain going with the next index.
    `SFD_ASSERT_NEXT(a_drain_runs, clk, rst_n, out_valid && frame.ready && !out_last,
        out_valid && (out_index == $past(out_index) + 1'b1),
        "drain stopped early or skipped an index")
endmodule
